@@ rtl/e2q_pkg.sv @@
// shared types, widths and constants for the euler to quaternion core
`timescale 1ns / 1ps

package e2q_pkg;

   localparam int NUM_AXES     = 3;
   localparam int AXIS_ROLL    = 0;
   localparam int AXIS_PITCH   = 1;
   localparam int AXIS_YAW     = 2;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W       = $clog2(ATAN_ENTRIES);

   localparam int ANGLE_W = 16;
   localparam int QUAT_W  = 16;
   localparam int XW      = 33;   // cordic x and y, q.30
   localparam int ZW      = 34;   // cordic angle, q.30
   localparam int SC_W    = 17;   // sine and cosine, q.15
   localparam int PW      = 2 * SC_W;
   localparam int TW      = PW + SC_W;
   localparam int HALF_SHIFT = 17;

   localparam logic signed [XW-1:0] GAIN_Q30    = XW'(33'sh026DD3B6A);
   localparam logic signed [ZW-1:0] PI_Q30      = ZW'(34'sh0C90FDAA2);
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(34'sh06487ED51);
   localparam logic signed [SC_W-1:0]   ONE_Q15 = SC_W'(32768);
   localparam logic signed [QUAT_W-1:0] ONE_Q14 = QUAT_W'(16384);

   localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic          flip;
      logic [ZW-1:0] z;
      logic [XW-1:0] y;
      logic [XW-1:0] x;
   } e2q_lane_type;

   typedef e2q_lane_type [NUM_AXES-1:0] e2q_lanes_type;

   // w in the lowest bits
   typedef struct packed {
      logic [QUAT_W-1:0] z;
      logic [QUAT_W-1:0] y;
      logic [QUAT_W-1:0] x;
      logic [QUAT_W-1:0] w;
   } e2q_quat_type;

   function automatic logic signed [ZW-1:0] atan_of(input logic [STEP_W-1:0] idx);
      return $signed({{(ZW-32){1'b0}}, ATAN_Q30[idx]});
   endfunction

endpackage

@@ rtl/e2q_cordic_cell.sv @@
// one rotation step of the cordic chain for all three axes
`timescale 1ns / 1ps

module e2q_cordic_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [e2q_pkg::STEP_W-1:0]  step_idx,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  e2q_pkg::e2q_lanes_type      in_lanes,
   output logic                        out_valid,
   input  logic                        out_ready,
   output e2q_pkg::e2q_lanes_type      out_lanes
);
   import e2q_pkg::*;

   logic          valid_ff;
   e2q_lanes_type lanes_ff;
   e2q_lanes_type lanes_in;

   always_comb begin
      logic signed [XW-1:0] xv;
      logic signed [XW-1:0] yv;
      logic signed [ZW-1:0] zv;
      logic signed [ZW-1:0] av;
      av = atan_of(step_idx);
      for (int k = 0; k < NUM_AXES; k++) begin
         xv = $signed(in_lanes[k].x);
         yv = $signed(in_lanes[k].y);
         zv = $signed(in_lanes[k].z);
         lanes_in[k].flip = in_lanes[k].flip;
         if (zv >= 0) begin
            lanes_in[k].x = xv - (yv >>> step_idx);
            lanes_in[k].y = yv + (xv >>> step_idx);
            lanes_in[k].z = zv - av;
         end else begin
            lanes_in[k].x = xv + (yv >>> step_idx);
            lanes_in[k].y = yv - (xv >>> step_idx);
            lanes_in[k].z = zv + av;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lanes_ff <= lanes_in;
      end
   end

endmodule

@@ rtl/e2q_quat_pipe.sv @@
// sine and cosine rounding, quaternion products and output register
`timescale 1ns / 1ps

module e2q_quat_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  e2q_pkg::e2q_lanes_type  in_lanes,
   output logic                    out_valid,
   input  logic                    out_ready,
   output e2q_pkg::e2q_quat_type   out_quat
);
   import e2q_pkg::*;

   localparam int NUM_STAGES = 4;
   localparam int ST_ROUND   = 0;
   localparam int ST_PAIR    = 1;
   localparam int ST_TRIPLE  = 2;
   localparam int ST_OUT     = 3;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   rdy;

   logic signed [SC_W-1:0] sin_ff [NUM_AXES];
   logic signed [SC_W-1:0] cos_ff [NUM_AXES];
   logic signed [SC_W-1:0] sin_in [NUM_AXES];
   logic signed [SC_W-1:0] cos_in [NUM_AXES];

   // yaw-pitch pair products, roll terms carried along
   logic signed [PW-1:0]   cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [SC_W-1:0] sr_ff, cr_ff;

   logic signed [TW-1:0]   t_ff [8];
   e2q_quat_type           quat_ff;
   e2q_quat_type           quat_in;

   function automatic logic signed [SC_W-1:0] round_q15(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      r = (v + XW'(16384)) >>> 15;
      if (r > XW'(ONE_Q15)) begin
         return ONE_Q15;
      end else if (r < -XW'(ONE_Q15)) begin
         return -ONE_Q15;
      end
      return r[SC_W-1:0];
   endfunction

   function automatic logic [QUAT_W-1:0] round_q14(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b,
                                                   input logic               sub);
      logic signed [TW:0] s;
      s = sub ? ((TW+1)'(a) - (TW+1)'(b)) : ((TW+1)'(a) + (TW+1)'(b));
      s = (s + ((TW+1)'(1) <<< 30)) >>> 31;
      if (s > (TW+1)'(ONE_Q14)) begin
         return ONE_Q14;
      end else if (s < -(TW+1)'(ONE_Q14)) begin
         return -ONE_Q14;
      end
      return s[QUAT_W-1:0];
   endfunction

   always_comb begin
      logic signed [XW-1:0] xv;
      logic signed [XW-1:0] yv;
      for (int k = 0; k < NUM_AXES; k++) begin
         xv = $signed(in_lanes[k].x);
         yv = $signed(in_lanes[k].y);
         if (in_lanes[k].flip) begin
            xv = -xv;
            yv = -yv;
         end
         cos_in[k] = round_q15(xv);
         sin_in[k] = round_q15(yv);
      end
   end

   always_comb begin
      quat_in.w = round_q14(t_ff[0], t_ff[1], 1'b0);
      quat_in.x = round_q14(t_ff[2], t_ff[3], 1'b1);
      quat_in.y = round_q14(t_ff[4], t_ff[5], 1'b0);
      quat_in.z = round_q14(t_ff[6], t_ff[7], 1'b1);
   end

   always_comb begin
      rdy[NUM_STAGES] = out_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[ST_ROUND];
   assign out_valid = valid_ff[ST_OUT];
   assign out_quat  = quat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[ST_ROUND]) valid_ff[ST_ROUND] <= in_valid;
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_ROUND] && in_valid) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
      if (rdy[ST_PAIR] && valid_ff[ST_ROUND]) begin
         cc_ff <= cos_ff[AXIS_YAW] * cos_ff[AXIS_PITCH];
         ss_ff <= sin_ff[AXIS_YAW] * sin_ff[AXIS_PITCH];
         sc_ff <= sin_ff[AXIS_YAW] * cos_ff[AXIS_PITCH];
         cs_ff <= cos_ff[AXIS_YAW] * sin_ff[AXIS_PITCH];
         sr_ff <= sin_ff[AXIS_ROLL];
         cr_ff <= cos_ff[AXIS_ROLL];
      end
      if (rdy[ST_TRIPLE] && valid_ff[ST_PAIR]) begin
         t_ff[0] <= cc_ff * cr_ff;
         t_ff[1] <= ss_ff * sr_ff;
         t_ff[2] <= cc_ff * sr_ff;
         t_ff[3] <= ss_ff * cr_ff;
         t_ff[4] <= sc_ff * sr_ff;
         t_ff[5] <= cs_ff * cr_ff;
         t_ff[6] <= sc_ff * cr_ff;
         t_ff[7] <= cs_ff * sr_ff;
      end
      if (rdy[ST_OUT] && valid_ff[ST_TRIPLE]) begin
         quat_ff <= quat_in;
      end
   end

`ifndef SYNTH
   a_out_w_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ($signed(out_quat.w) <= ONE_Q14 && $signed(out_quat.w) >= -ONE_Q14))
      else $error("quat_w out of range");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_ROUND] |-> (sin_ff[AXIS_ROLL] <= ONE_Q15 && sin_ff[AXIS_ROLL] >= -ONE_Q15))
      else $error("roll sine out of range");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_TRIPLE] && rdy[ST_OUT] |=> valid_ff[ST_OUT])
      else $error("word lost before output register");
`endif

endmodule

@@ rtl/euler_to_quaternion_core.sv @@
// top level: angle halving and folding, cordic cell chain, quaternion pipeline
//
// channel  dir  tdata fields (lowest bits first)
// req_     in   roll_angle[15:0] pitch_angle[31:16] yaw_angle[47:32], signed q3.12
// rsp_     out  quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48], signed q1.14
//
// one word per cycle sustained while rsp_tready stays high
// the fold register feeds a chain of cordic cells, one rotation step per cell
// every stage holds its word under backpressure and bubbles are squeezed out
// reset is synchronous and clears only the valid bits
`timescale 1ns / 1ps

module euler_to_quaternion_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // roll_angle, pitch_angle, yaw_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // quat_w, quat_x, quat_y, quat_z
);
   import e2q_pkg::*;

   logic          fold_valid_ff;
   e2q_lanes_type fold_lanes_ff;
   e2q_lanes_type fold_lanes_in;

   logic          chain_valid [NUM_CELLS+1];
   logic          chain_ready [NUM_CELLS+1];
   e2q_lanes_type chain_lanes [NUM_CELLS+1];

   e2q_quat_type  quat;

   always_comb begin
      logic signed [ANGLE_W-1:0] a;
      logic signed [ZW-1:0]      zv;
      for (int k = 0; k < NUM_AXES; k++) begin
         a  = $signed(req_tdata[k*ANGLE_W +: ANGLE_W]);
         zv = ZW'(a) <<< HALF_SHIFT;
         fold_lanes_in[k].x    = GAIN_Q30;
         fold_lanes_in[k].y    = '0;
         fold_lanes_in[k].flip = 1'b0;
         if (zv > HALF_PI_Q30) begin
            zv = zv - PI_Q30;
            fold_lanes_in[k].flip = 1'b1;
         end else if (zv < -HALF_PI_Q30) begin
            zv = zv + PI_Q30;
            fold_lanes_in[k].flip = 1'b1;
         end
         fold_lanes_in[k].z = zv;
      end
   end

   assign req_tready = !fold_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (req_tready) begin
         fold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         fold_lanes_ff <= fold_lanes_in;
      end
   end

   assign chain_valid[0] = fold_valid_ff;
   assign chain_lanes[0] = fold_lanes_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      e2q_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_lanes  (chain_lanes[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_lanes (chain_lanes[g+1])
      );
   end

   e2q_quat_pipe u_quat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NUM_CELLS]),
      .in_ready  (chain_ready[NUM_CELLS]),
      .in_lanes  (chain_lanes[NUM_CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_quat  (quat)
   );

   assign rsp_tdata = quat;

`ifndef SYNTH
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> fold_valid_ff)
      else $error("accepted word not held in fold stage");

   a_fold_hold: assert property (@(posedge clock) disable iff (reset)
      fold_valid_ff && !chain_ready[0] |=> fold_valid_ff && $stable(fold_lanes_ff))
      else $error("fold stage changed while stalled");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      fold_valid_ff |-> ($signed(fold_lanes_ff[AXIS_YAW].z) <= HALF_PI_Q30 &&
                         $signed(fold_lanes_ff[AXIS_YAW].z) >= -HALF_PI_Q30))
      else $error("folded yaw half angle out of range");
`endif

endmodule

@@ sim/tb_euler_to_quaternion_core.sv @@
// testbench for euler_to_quaternion_core: streams angle sets, checks each quaternion word
`timescale 1ns / 1ps

module tb_euler_to_quaternion_core;
   import e2q_pkg::*;

   localparam int     ROT_STEPS   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int     TAIL_CYCLES = 1 + CORDIC_STEPS + 4 + 40;
   localparam int     RANDOM_SETS = 750;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint GAIN_FIX    = 64'sh26DD3B6A;
   localparam longint PI_FIX      = 64'shC90FDAA2;
   localparam longint HALF_PI_FIX = 64'sh6487ED51;
   localparam logic [15:0] FOLD_EDGE = 16'd12868;
   localparam logic [15:0] QUARTER   = 16'd6434;

   localparam longint ATAN_TAB [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   typedef struct {
      logic [47:0] angles;   // roll, pitch, yaw from the lowest bits up
      int unsigned gap;
   } angle_set_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // roll_angle, pitch_angle, yaw_angle
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // quat_w, quat_x, quat_y, quat_z

   angle_set_type angle_pending[$];
   e2q_quat_type  quat_due[$];
   string         field_name [4] = '{"quat_w", "quat_x", "quat_y", "quat_z"};

   int unsigned error_count = 0;
   int unsigned angle_sent  = 0;
   int unsigned quat_seen   = 0;
   int unsigned gap_left    = 0;
   bit          gap_armed   = 1'b0;
   int unsigned stall_left  = 0;
   logic        hold_off    = 1'b0;
   longint      cycle_count = 0;

   euler_to_quaternion_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial forever #4 clock = ~clock;

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // sine and cosine of half the angle, q.15
   function automatic void half_sin_cos(input logic [15:0] angle,
                                        output longint sin_q15, output longint cos_q15);
      longint z, x, y, nx;
      bit     flip;
      int     i;
      z    = longint'($signed(angle)) * 64'sd131072;
      x    = GAIN_FIX;
      y    = 0;
      flip = 1'b0;
      if (z > HALF_PI_FIX) begin
         z    = z - PI_FIX;
         flip = 1'b1;
      end else if (z < -HALF_PI_FIX) begin
         z    = z + PI_FIX;
         flip = 1'b1;
      end
      for (i = 0; i < ROT_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TAB[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TAB[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos_q15 = clamp_sym((x + 16384) >>> 15, 32768);
      sin_q15 = clamp_sym((y + 16384) >>> 15, 32768);
   endfunction

   function automatic logic [15:0] round_q14(input longint q45);
      longint v;
      v = clamp_sym((q45 + 64'sd1073741824) >>> 31, 16384);
      return 16'(v);
   endfunction

   function automatic e2q_quat_type rotate_to_quat(input logic [47:0] angles);
      longint       sr, cr, sp, cp, sy, cy, cc, ss, sc, cs;
      e2q_quat_type q;
      half_sin_cos(angles[15:0],  sr, cr);
      half_sin_cos(angles[31:16], sp, cp);
      half_sin_cos(angles[47:32], sy, cy);
      cc  = cy * cp;
      ss  = sy * sp;
      sc  = sy * cp;
      cs  = cy * sp;
      q.w = round_q14(cc * cr + ss * sr);
      q.x = round_q14(cc * sr - ss * cr);
      q.y = round_q14(sc * sr + cs * cr);
      q.z = round_q14(sc * cr - cs * sr);
      return q;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %s", msg);
      error_count++;
   endtask

   task automatic queue_angles(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw, input int unsigned gap);
      angle_set_type s;
      s.angles = {yaw, pitch, roll};
      s.gap    = gap;
      angle_pending = {angle_pending, s};
   endtask

   // mostly full range, some near the fold point and near zero
   function automatic logic [15:0] draw_angle();
      logic [15:0] a;
      case ($urandom_range(0, 7))
         0: begin
            a = FOLD_EDGE + 16'($urandom_range(0, 8)) - 16'd4;
            if ($urandom_range(0, 1)) a = -a;
         end
         1: a = 16'($urandom_range(0, 127)) - 16'd64;
         default: a = 16'($urandom_range(0, 65535));
      endcase
      return a;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_armed  = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            quat_due = {quat_due, rotate_to_quat(req_tdata)};
            angle_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (angle_pending.size() > 0) begin
               if (!gap_armed) begin
                  gap_left  = angle_pending[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left == 0) begin
                  req_tdata  <= angle_pending[0].angles;
                  req_tvalid <= 1'b1;
                  void'(angle_pending.pop_front());
                  gap_armed  = 1'b0;
               end else begin
                  gap_left--;
                  req_tvalid <= 1'b0;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      e2q_quat_type want;
      logic [63:0]  want_bits;
      int           k;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (quat_due.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with nothing pending: %h",
                                         quat_seen, rsp_tdata));
            end else begin
               want      = quat_due.pop_front();
               want_bits = want;
               for (k = 0; k < 4; k++) begin
                  if (rsp_tdata[k*16 +: 16] !== want_bits[k*16 +: 16])
                     report_mismatch($sformatf("word %0d %s: got %0d expected %0d",
                                               quat_seen, field_name[k],
                                               $signed(rsp_tdata[k*16 +: 16]),
                                               $signed(want_bits[k*16 +: 16])));
               end
            end
            quat_seen++;
            stall_left = (((quat_seen / 96) % 4) == 2) ? 0 : $urandom_range(0, 13);
         end
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the pipeline fills and stalls its input
   initial begin
      while (quat_seen < 120) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("euler_to_quaternion_core: mismatch");
         $finish;
      end
   end

   initial begin
      int n;
      queue_angles(16'd0, 16'd0, 16'd0, 0);
      queue_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, $urandom_range(0, 13));
      queue_angles(16'h8000, 16'h8000, 16'h8000, $urandom_range(0, 13));
      queue_angles(16'h7FFF, 16'd0, 16'd0, 0);
      queue_angles(16'd0, 16'h7FFF, 16'd0, 0);
      queue_angles(16'd0, 16'd0, 16'h7FFF, $urandom_range(0, 13));
      queue_angles(16'h8000, 16'd0, 16'd0, 0);
      queue_angles(16'd0, 16'h8000, 16'd0, 0);
      queue_angles(16'd0, 16'd0, 16'h8000, $urandom_range(0, 13));
      // both sides of the quadrant fold
      queue_angles(FOLD_EDGE - 16'd1, FOLD_EDGE, -(FOLD_EDGE - 16'd1), 0);
      queue_angles(-FOLD_EDGE, FOLD_EDGE - 16'd1, FOLD_EDGE, 0);
      queue_angles(FOLD_EDGE, -FOLD_EDGE, -(FOLD_EDGE - 16'd1), $urandom_range(0, 13));
      queue_angles(FOLD_EDGE, 16'd0, 16'd0, 0);
      queue_angles(16'd0, FOLD_EDGE, 16'd0, 0);
      queue_angles(16'd0, 16'd0, FOLD_EDGE, $urandom_range(0, 13));
      queue_angles(QUARTER, QUARTER, QUARTER, 0);
      queue_angles(-QUARTER, QUARTER, -QUARTER, $urandom_range(0, 13));
      queue_angles(16'h5555, 16'hAAAA, 16'h5555, 0);
      queue_angles(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      queue_angles(16'd1, 16'hFFFF, 16'd1, $urandom_range(0, 13));
      queue_angles(16'd0, QUARTER, 16'd0, 0);
      queue_angles(16'd0, -QUARTER, 16'd0, 0);
      for (n = 0; n < RANDOM_SETS; n++)
         queue_angles(draw_angle(), draw_angle(), draw_angle(),
                      (((n / 80) % 3) == 1) ? 0 : $urandom_range(0, 13));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (angle_pending.size() > 0 || req_tvalid || quat_due.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (quat_due.size() > 0)
         report_mismatch($sformatf("%0d quaternion words never arrived", quat_due.size()));

      if (error_count == 0) begin
         $display("euler_to_quaternion_core: match");
      end else begin
         $display("euler_to_quaternion_core: mismatch");
      end
      $finish;
   end

endmodule
